// ===== src/hpq_pkg.sv =====
package hpq_pkg;

  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef logic [MODE_W-1:0]          mode_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // request operations
  localparam mode_t MODE_INSERT  = 2'd0;
  localparam mode_t MODE_EXTRACT = 2'd1;
  localparam mode_t MODE_REPLACE = 2'd2;
  localparam mode_t MODE_PEEK    = 2'd3;

  // response status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

// ===== src/hpq_ifs.sv =====
interface hpq_req_if;
  logic           valid;
  logic           ready;
  hpq_pkg::mode_t  mode;
  hpq_pkg::value_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface hpq_rsp_if;
  logic             valid;
  logic             ready;
  hpq_pkg::value_t  top_value;
  hpq_pkg::status_t status;
  hpq_pkg::count_t  entry_count;

  modport source (output valid, output top_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input top_value, input status, input entry_count,
                output ready);
endinterface

// ===== src/max_heap_priority_queue.sv =====
// channel | dir | payload                              | one transaction
// --------+-----+--------------------------------------+-------------------------------
// req     | in  | mode, value                          | one heap operation
// rsp     | out | top_value, status, entry_count       | one result per operation
//
// one operation at a time, stepping through the sequencer states below
// flagged request: idle, result; peek, or extract / replace on a one-entry heap:
//   idle, load, result; insert: idle, sift-up once per level climbed, put or result
// extract / replace: idle, load, sift-down once per level descended, put or result
//   (both children read in the same cycle from the two read ports of the heap memory)
// reset clears count and control only
// a new request is taken while a finished result still waits on rsp; the block stalls
//   before loading a further result until the previous one is taken

module max_heap_priority_queue #(
  parameter int HEAP_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  hpq_req_if.sink    req,
  hpq_rsp_if.source  rsp
);

  // index widths: AW addresses the store, CW holds the count, IW holds child indexes
  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;
  localparam int OW = hpq_pkg::COUNT_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DN     = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  // heap store: one write port, two registered read ports
  hpq_pkg::value_t heap_mem [HEAP_DEPTH];
  hpq_pkg::value_t rd_a;
  hpq_pkg::value_t rd_b;
  logic [AW-1:0]   ra;
  logic [AW-1:0]   rb;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  hpq_pkg::value_t mem_wd;

  // control and working registers
  logic [2:0]       state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    pos, pos_next;
  hpq_pkg::value_t  mov, mov_next;
  hpq_pkg::value_t  top, top_next;
  hpq_pkg::value_t  val_r, val_next;
  hpq_pkg::mode_t   mode_r, mode_next;
  hpq_pkg::status_t status_r, status_next;

  // output register
  logic             rsp_valid;
  hpq_pkg::value_t  rsp_top;
  hpq_pkg::status_t rsp_status;
  hpq_pkg::count_t  rsp_count;
  logic             rsp_load;
  logic             out_free;

  // index arithmetic
  logic [IW-1:0]   pos_w, cnt_w, cnt_m1, in_par;
  logic [IW-1:0]   par_pos, par_par;
  logic [IW-1:0]   c_idx, c_idx_p1, cs, nc, nc_p1;
  logic [IW-1:0]   one_w, two_w;
  logic            right_ok, pick_r;
  hpq_pkg::value_t big;
  hpq_pkg::value_t mov_sel;

  assign pos_w    = IW'(pos);
  assign cnt_w    = IW'(count);
  assign cnt_m1   = cnt_w - 1'b1;
  assign in_par   = cnt_m1 >> 1;
  assign par_pos  = (pos_w - 1'b1) >> 1;
  assign par_par  = (par_pos - 1'b1) >> 1;
  assign one_w    = IW'(1);
  assign two_w    = IW'(2);

  // sift-down: pick the larger child, right one only when it is below the count
  assign c_idx    = (pos_w << 1) + 1'b1;
  assign c_idx_p1 = c_idx + 1'b1;
  assign right_ok = c_idx_p1 < cnt_w;
  assign pick_r   = right_ok && (rd_b > rd_a);
  assign big      = pick_r ? rd_b : rd_a;
  assign cs       = pick_r ? c_idx_p1 : c_idx;
  assign nc       = (cs << 1) + 1'b1;
  assign nc_p1    = nc + 1'b1;

  // extract moves the last entry to the root, replace puts the new value there
  assign mov_sel  = (mode_r == hpq_pkg::MODE_EXTRACT) ? rd_b : val_r;

  assign out_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    mov_next    = mov;
    top_next    = top;
    val_next    = val_r;
    mode_next   = mode_r;
    status_next = status_r;
    ra          = '0;
    rb          = '0;
    mem_we      = 1'b0;
    mem_wa      = pos;
    mem_wd      = mov;
    rsp_load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          mode_next   = req.mode;
          val_next    = req.value;
          top_next    = '0;
          status_next = hpq_pkg::ST_OK;
          if (req.mode == hpq_pkg::MODE_INSERT) begin
            if (cnt_w >= IW'(HEAP_DEPTH)) begin
              // full: drop the value
              status_next = hpq_pkg::ST_FULL;
              state_next  = S_RESULT;
            end else begin
              count_next = count + 1'b1;
              pos_next   = count[AW-1:0];
              mov_next   = req.value;
              ra         = in_par[AW-1:0];
              state_next = (count == '0) ? S_PUT : S_UP;
            end
          end else if (count == '0) begin
            status_next = hpq_pkg::ST_EMPTY;
            state_next  = S_RESULT;
          end else begin
            // fetch root and last entry together
            ra = '0;
            rb = cnt_m1[AW-1:0];
            if (req.mode == hpq_pkg::MODE_EXTRACT) begin
              count_next = count - 1'b1;
            end
            state_next = S_LOAD;
          end
        end
      end
      S_UP: begin
        // rd_a holds the parent of pos
        mem_we = 1'b1;
        mem_wa = pos;
        if (mov > rd_a) begin
          mem_wd   = rd_a;
          pos_next = par_pos[AW-1:0];
          if (par_pos == '0) begin
            state_next = S_PUT;
          end else begin
            ra = par_par[AW-1:0];
          end
        end else begin
          mem_wd     = mov;
          state_next = S_RESULT;
        end
      end
      S_LOAD: begin
        top_next = rd_a;
        if (mode_r == hpq_pkg::MODE_PEEK) begin
          state_next = S_RESULT;
        end else begin
          mov_next = mov_sel;
          pos_next = '0;
          if (count == '0) begin
            // the only entry was taken out
            state_next = S_RESULT;
          end else if (count == CW'(1)) begin
            mem_we     = 1'b1;
            mem_wa     = '0;
            mem_wd     = mov_sel;
            state_next = S_RESULT;
          end else begin
            ra         = one_w[AW-1:0];
            rb         = two_w[AW-1:0];
            state_next = S_DN;
          end
        end
      end
      S_DN: begin
        // rd_a and rd_b hold the children of pos
        mem_we = 1'b1;
        mem_wa = pos;
        if (big > mov) begin
          mem_wd   = big;
          pos_next = cs[AW-1:0];
          if (nc >= cnt_w) begin
            state_next = S_PUT;
          end else begin
            ra = nc[AW-1:0];
            rb = nc_p1[AW-1:0];
          end
        end else begin
          mem_wd     = mov;
          state_next = S_RESULT;
        end
      end
      S_PUT: begin
        mem_we     = 1'b1;
        mem_wa     = pos;
        mem_wd     = mov;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // heap memory
  always_ff @(posedge clk) begin
    rd_a <= heap_mem[ra];
    rd_b <= heap_mem[rb];
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    mov      <= mov_next;
    top      <= top_next;
    val_r    <= val_next;
    mode_r   <= mode_next;
    status_r <= status_next;
    if (rsp_load) begin
      rsp_top    <= top;
      rsp_status <= status_r;
      rsp_count  <= OW'(count);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.top_value   = rsp_top;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_IDLE && state != S_RESULT))
    else $error("store written outside an operation");

  a_up_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP) |-> (pos != '0))
    else $error("sift-up running at the root");

  a_dn_child: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN) |-> (c_idx < cnt_w))
    else $error("sift-down reading past the last entry");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> (rsp_valid && state == S_IDLE))
    else $error("result not presented after load");
`endif

endmodule
